>>> hdl/idsc_pkg.sv
package idsc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MASK_INIT  = 2'd0,
    REG_MASK_STEP  = 2'd1,
    REG_BLOCK_SIZE = 2'd2,
    REG_CRYPT_LEN  = 2'd3
  } cfg_reg_t;

  // result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // buffer access requests from the front
  typedef struct packed {
    logic wr_en;
    logic wr_bank;
    logic rd_en;
    logic rd_bank;
  } ram_ctl_t;

  // classified beat waiting for its buffer read data
  typedef struct packed {
    logic valid;
    logic has_byte;
    logic last_byte;
    logic rejected;
    logic bank;
  } desc_t;

  // finished result beat
  typedef struct packed {
    logic       has_byte;
    logic [7:0] plain_byte;
    logic       last_byte;
    logic       rejected;
  } result_t;

endpackage

>>> hdl/idsc_ram.sv
module idsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/idsc_front.sv
module idsc_front #(
  parameter int MAX_BLOCK = 32768,
  localparam int AW = $clog2(MAX_BLOCK),
  localparam int CW = $clog2(MAX_BLOCK + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  idsc_pkg::cfg_reg_t           cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [7:0]                   in_byte,
  input  logic                         in_eom,
  input  logic [idsc_pkg::QCW-1:0]     q_count,
  output idsc_pkg::ram_ctl_t           ram_ctl,
  output logic [AW-1:0]                wr_addr,
  output logic [7:0]                   wr_data,
  output logic [AW-1:0]                rd_addr,
  output idsc_pkg::desc_t              desc
);
  import idsc_pkg::*;

  localparam int LIM  = (MAX_BLOCK / 2) * 2;
  localparam int CMPW = (CW > 16) ? CW : 16;

  // configuration
  logic [7:0]  mask_init_r, mask_step_r;
  logic [15:0] block_size_r;
  logic [31:0] crypt_len_r;

  // message and chunk state
  logic [7:0]    mask_r, mask_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [CW-1:0] fill_cnt_r, fill_cnt_nxt;
  logic          fill_dec_r, fill_dec_nxt;
  logic          fill_ready_r, fill_ready_nxt;
  logic          fill_last_r, fill_last_nxt;
  logic          fill_bank_r, fill_bank_nxt;
  logic [CW-1:0] drain_idx_r, drain_idx_nxt;
  logic [CW-1:0] drain_len_r, drain_len_nxt;
  logic          drain_dec_r, drain_dec_nxt;
  logic          drain_active_r, drain_active_nxt;
  logic          drain_last_r, drain_last_nxt;
  desc_t         desc_r, desc_nxt;

  logic            take;
  logic [QCW-1:0]  pending;
  logic [15:0]     bs_even;
  logic [CMPW-1:0] eff_blk;
  logic [CW-1:0]   drain_even, raddr_c, idx_inc;
  logic            d_active, d_dec, d_last, emit_last;
  logic            move_a, move_b;
  logic [CW-1:0]   f_cnt, g_cnt;
  logic            f_ready, f_dec, f_last, f_bank;
  logic            g_ready, g_dec, g_last;
  logic            wr_req, rej, in_crypt;
  logic [7:0]      mask_v, wr_val;

  assign pending  = q_count + QCW'(desc_r.valid);
  assign in_ready = pending < QCW'(QDEPTH);
  assign take     = in_valid && in_ready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_init_r  <= 8'd0;
      mask_step_r  <= 8'd0;
      block_size_r <= 16'd128;
      crypt_len_r  <= 32'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MASK_INIT:  mask_init_r  <= cfg_data[7:0];
        REG_MASK_STEP:  mask_step_r  <= cfg_data[7:0];
        REG_BLOCK_SIZE: block_size_r <= cfg_data[15:0];
        REG_CRYPT_LEN:  crypt_len_r  <= cfg_data;
      endcase
    end
  end

  // even chunk size, at least 2, clamped to the buffer depth
  always_comb begin
    bs_even = {block_size_r[15:1], 1'b0};
    priority if (bs_even < 16'd2) begin
      eff_blk = CMPW'(2);
    end else if (CMPW'(bs_even) > CMPW'(LIM)) begin
      eff_blk = CMPW'(LIM);
    end else begin
      eff_blk = CMPW'(bs_even);
    end
  end

  // drain address, decrypted chunk: first half to odd slots, second half to even slots, each from its end
  always_comb begin
    drain_even = {drain_len_r[CW-1:1], 1'b0};
    priority if (!drain_dec_r || drain_idx_r >= drain_even) begin
      raddr_c = drain_idx_r;
    end else if (drain_idx_r[0]) begin
      raddr_c = (drain_even - CW'(1) - drain_idx_r) >> 1;
    end else begin
      raddr_c = drain_even - CW'(1) - (drain_idx_r >> 1);
    end
  end

  assign rd_addr = raddr_c[AW-1:0];

  always_comb begin
    // emit side
    idx_inc   = drain_idx_r + CW'(1);
    d_active  = drain_active_r;
    d_dec     = drain_dec_r;
    d_last    = drain_last_r;
    emit_last = 1'b0;
    if (drain_active_r && idx_inc >= drain_len_r) begin
      emit_last = drain_last_r;
      d_active  = 1'b0;
      d_dec     = 1'b0;
      d_last    = 1'b0;
    end

    // swap before the incoming beat lands
    move_a  = fill_ready_r && !d_active;
    f_cnt   = move_a ? '0 : fill_cnt_r;
    f_ready = move_a ? 1'b0 : fill_ready_r;
    f_dec   = move_a ? 1'b0 : fill_dec_r;
    f_last  = move_a ? 1'b0 : fill_last_r;
    f_bank  = move_a ? ~fill_bank_r : fill_bank_r;

    // fill side
    g_cnt    = f_cnt;
    g_ready  = f_ready;
    g_dec    = f_dec;
    g_last   = f_last;
    mask_v   = mask_r;
    pos_nxt  = pos_r;
    wr_req   = 1'b0;
    rej      = 1'b0;
    wr_val   = in_byte;
    in_crypt = pos_r < crypt_len_r;
    if (!in_op) begin
      if (f_ready) begin
        rej = 1'b1;
      end else begin
        if (f_cnt == '0) begin
          if (pos_r == 32'd0) begin
            mask_v = mask_init_r;
          end
          g_dec = in_crypt;
        end
        // trailing odd byte of a message is not decrypted: written as zero inside the encrypted span, else passed as is
        priority if (in_eom && !f_cnt[0]) begin
          wr_val = in_crypt ? 8'd0 : in_byte;
        end else if (g_dec) begin
          wr_val = in_byte ^ mask_v;
          mask_v = mask_v + mask_step_r;
        end else begin
          wr_val = in_byte;
        end
        wr_req  = 1'b1;
        g_cnt   = f_cnt + CW'(1);
        pos_nxt = pos_r + 32'd1;
        if (in_eom) begin
          g_ready = 1'b1;
          g_last  = 1'b1;
          pos_nxt = 32'd0;
        end else if (!g_cnt[0] && CMPW'(g_cnt) >= eff_blk) begin
          g_ready = 1'b1;
        end
      end
    end
    mask_nxt = mask_v;

    // swap after the beat lands
    move_b = !move_a && g_ready && !d_active;

    priority if (move_a) begin
      drain_len_nxt    = fill_cnt_r;
      drain_idx_nxt    = '0;
      drain_active_nxt = 1'b1;
      drain_dec_nxt    = fill_dec_r;
      drain_last_nxt   = fill_last_r;
    end else if (move_b) begin
      drain_len_nxt    = g_cnt;
      drain_idx_nxt    = '0;
      drain_active_nxt = 1'b1;
      drain_dec_nxt    = g_dec;
      drain_last_nxt   = g_last;
    end else begin
      drain_len_nxt    = drain_len_r;
      drain_idx_nxt    = drain_active_r ? idx_inc : drain_idx_r;
      drain_active_nxt = d_active;
      drain_dec_nxt    = d_dec;
      drain_last_nxt   = d_last;
    end

    if (move_b) begin
      fill_cnt_nxt   = '0;
      fill_ready_nxt = 1'b0;
      fill_dec_nxt   = 1'b0;
      fill_last_nxt  = 1'b0;
      fill_bank_nxt  = ~f_bank;
    end else begin
      fill_cnt_nxt   = g_cnt;
      fill_ready_nxt = g_ready;
      fill_dec_nxt   = g_dec;
      fill_last_nxt  = g_last;
      fill_bank_nxt  = f_bank;
    end

    desc_nxt.valid     = take;
    desc_nxt.has_byte  = drain_active_r;
    desc_nxt.last_byte = emit_last;
    desc_nxt.rejected  = rej;
    desc_nxt.bank      = ~fill_bank_r;
  end

  assign ram_ctl.wr_en   = take && wr_req;
  assign ram_ctl.wr_bank = f_bank;
  assign ram_ctl.rd_en   = take && drain_active_r;
  assign ram_ctl.rd_bank = ~fill_bank_r;
  assign wr_addr         = f_cnt[AW-1:0];
  assign wr_data         = wr_val;
  assign desc            = desc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r         <= 8'd0;
      pos_r          <= 32'd0;
      fill_cnt_r     <= '0;
      fill_dec_r     <= 1'b0;
      fill_ready_r   <= 1'b0;
      fill_last_r    <= 1'b0;
      fill_bank_r    <= 1'b0;
      drain_idx_r    <= '0;
      drain_len_r    <= '0;
      drain_dec_r    <= 1'b0;
      drain_active_r <= 1'b0;
      drain_last_r   <= 1'b0;
    end else if (take) begin
      mask_r         <= mask_nxt;
      pos_r          <= pos_nxt;
      fill_cnt_r     <= fill_cnt_nxt;
      fill_dec_r     <= fill_dec_nxt;
      fill_ready_r   <= fill_ready_nxt;
      fill_last_r    <= fill_last_nxt;
      fill_bank_r    <= fill_bank_nxt;
      drain_idx_r    <= drain_idx_nxt;
      drain_len_r    <= drain_len_nxt;
      drain_dec_r    <= drain_dec_nxt;
      drain_active_r <= drain_active_nxt;
      drain_last_r   <= drain_last_nxt;
    end
  end

  // only the valid flag needs a reset; the payload is loaded with each taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r.valid <= 1'b0;
    end else begin
      desc_r.valid <= desc_nxt.valid;
    end
    if (take) begin
      desc_r.has_byte  <= desc_nxt.has_byte;
      desc_r.last_byte <= desc_nxt.last_byte;
      desc_r.rejected  <= desc_nxt.rejected;
      desc_r.bank      <= desc_nxt.bank;
    end
  end

  a_ready_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fill_ready_r |-> fill_cnt_r != '0)
    else $error("closed fill chunk holds no bytes");

  a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    drain_active_r |-> drain_idx_r < drain_len_r)
    else $error("drain index ran past chunk length");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_ctl.wr_en |-> (!f_ready && CW'(f_cnt) < CW'(MAX_BLOCK)))
    else $error("write into a closed or overfull fill buffer");

endmodule

>>> hdl/idsc_queue.sv
module idsc_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  idsc_pkg::result_t        push_data,
  output logic [idsc_pkg::QCW-1:0] count,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata,
  output logic                     out_tlast,
  output logic [1:0]               out_tuser
);
  import idsc_pkg::*;

  result_t        q_r [QDEPTH];
  result_t        head;
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           pop;

  assign pop = out_tvalid && out_tready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
    end
    count_nxt = count_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign head       = q_r[rd_ptr_r];
  assign count      = count_r;
  assign out_tvalid = count_r != '0;
  assign out_tdata  = head.plain_byte;
  assign out_tlast  = head.last_byte;
  assign out_tuser  = {head.rejected, head.has_byte};

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != QCW'(QDEPTH)) || pop)
    else $error("result queue overflow");

endmodule

>>> hdl/interleaved_block_xor_descrambler.sv
// path: a taken input beat is registered as a descriptor beside its buffer read, then
//   pushed into the result queue, from which it is offered
// throughput: one input and one result beat per cycle while the result queue has room,
//   across chunk swaps too; each buffer bank sees at most one write and one registered read per cycle
// reset: synchronous, active low; clears configuration to defaults, message and chunk
//   state and the result queue; buffer contents are left as is, no clearing pass
module interleaved_block_xor_descrambler #(
  parameter int MAX_BLOCK = 32768
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  idsc_pkg::cfg_reg_t cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] cipher_byte
  input  logic               in_tlast,   // end_of_message
  input  logic               in_tuser,   // [0] operation
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [7:0] plain_byte
  output logic               out_tlast,  // last_byte
  output logic [1:0]         out_tuser   // [0] has_byte, [1] rejected
);
  import idsc_pkg::*;

  localparam int AW = $clog2(MAX_BLOCK);

  ram_ctl_t       ram_ctl;
  desc_t          desc;
  result_t        result;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [7:0]     wr_data, rdata0, rdata1;
  logic [QCW-1:0] q_count;

  assign cfg_ready = 1'b1;

  idsc_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_byte  (in_tdata),
    .in_eom   (in_tlast),
    .q_count  (q_count),
    .ram_ctl  (ram_ctl),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .desc     (desc)
  );

  // ping-pong banks
  idsc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BLOCK)
  ) u_bank0 (
    .clk  (clk),
    .we   (ram_ctl.wr_en && !ram_ctl.wr_bank),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (ram_ctl.rd_en && !ram_ctl.rd_bank),
    .raddr(rd_addr),
    .rdata(rdata0)
  );

  idsc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BLOCK)
  ) u_bank1 (
    .clk  (clk),
    .we   (ram_ctl.wr_en && ram_ctl.wr_bank),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (ram_ctl.rd_en && ram_ctl.rd_bank),
    .raddr(rd_addr),
    .rdata(rdata1)
  );

  // join the classified beat with its read data
  always_comb begin
    result.has_byte   = desc.has_byte;
    result.plain_byte = desc.has_byte ? (desc.bank ? rdata1 : rdata0) : 8'd0;
    result.last_byte  = desc.last_byte;
    result.rejected   = desc.rejected;
  end

  idsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc.valid),
    .push_data (result),
    .count     (q_count),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (desc.valid && !desc.has_byte) |-> (result.plain_byte == 8'd0 && !result.last_byte))
    else $error("idle result carries data");

endmodule
